[rtl/core/mhpq_pkg.sv]
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants of the max priority queue
// Command and error codes, payload field widths and the control word
// that the top level hands to every storage cell.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;
    localparam int TOP_W   = 32;
    localparam int ERR_W   = 2;
    localparam int IN_TDATA_W = ((CMD_W + VALUE_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

[rtl/core/mhpq_cell.sv]
// ----------------------------------------------------------------------------
// mhpq_cell: one storage cell of the sorted cell row
// Holds one element. On a push the cell keeps its element, takes the new
// element or takes its upper neighbor's element; on a pop it takes its
// lower neighbor's element.
// ----------------------------------------------------------------------------
module mhpq_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  mhpq_pkg::cell_ctrl_t         ctrl,
    input  logic                         valid,
    input  logic signed [DATA_WIDTH-1:0] push_value,
    input  logic signed [DATA_WIDTH-1:0] prev_data,
    input  logic                         prev_gt,
    input  logic signed [DATA_WIDTH-1:0] next_data,
    output logic signed [DATA_WIDTH-1:0] data,
    output logic signed [DATA_WIDTH-1:0] data_next,
    output logic                         gt
);

    logic signed [DATA_WIDTH-1:0] data_reg;

    // The new element belongs at or above this cell.
    assign gt = !valid || (push_value > data_reg);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.push && gt)
        begin
            data_next = prev_gt ? prev_data : push_value;
        end
        else if (ctrl.pop)
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[rtl/core/max_heap_priority_queue.sv]
// A result beat is offered in the cycle after its command beat is accepted.
// One command per cycle while results are taken; the whole cell row shifts or
// inserts at once, in one registered update per command.
// Reset clears the element count and the result valid flag; cell contents are
// undefined until written and are never read before that.
// ----------------------------------------------------------------------------
// max_heap_priority_queue: max priority queue on a sorted row of cells
// Push inserts in order, pop shifts the row up, clear empties the queue.
// Every command returns the maximum, occupancy, empty flag and error code.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32,
    localparam int OCC_W = $clog2(CAPACITY + 1),
    localparam int OUT_W = ((mhpq_pkg::TOP_W + OCC_W + 1 + mhpq_pkg::ERR_W + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mhpq_pkg::IN_TDATA_W-1:0]   s_tdata,  // cmd, value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [OUT_W-1:0]                  m_tdata   // top_value, occupancy,
                                                        // is_empty, error_code
);

    logic [OCC_W-1:0]                    count_reg;
    logic [OCC_W-1:0]                    count_next;
    logic                                out_valid_reg;
    logic [mhpq_pkg::TOP_W-1:0]          top_reg;
    logic [OCC_W-1:0]                    occ_reg;
    logic                                empty_reg;
    logic [mhpq_pkg::ERR_W-1:0]          err_reg;
    logic [mhpq_pkg::ERR_W-1:0]          err_next;
    logic                                accept;
    logic [mhpq_pkg::CMD_W-1:0]          cmd;
    logic signed [mhpq_pkg::VALUE_W-1:0] value_in;
    logic signed [DATA_WIDTH-1:0]        push_value;
    logic                                full;
    mhpq_pkg::cell_ctrl_t                ctrl;
    logic signed [DATA_WIDTH-1:0]        cell_data [CAPACITY];
    logic signed [DATA_WIDTH-1:0]        cell_data_next [CAPACITY];
    logic                                cell_gt [CAPACITY];
    logic signed [63:0]                  top_ext_next;
    logic signed [63:0]                  top_ext_now;

    assign s_tready   = !out_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign cmd        = s_tdata[mhpq_pkg::CMD_W-1:0];
    assign value_in   = s_tdata[mhpq_pkg::CMD_W +: mhpq_pkg::VALUE_W];
    assign push_value = DATA_WIDTH'(64'(value_in));
    assign full       = (count_reg == OCC_W'(CAPACITY));

    always_comb
    begin
        ctrl       = '0;
        count_next = count_reg;
        err_next   = mhpq_pkg::ERR_OK;
        case (cmd)
            mhpq_pkg::CMD_PUSH:
            begin
                if (full)
                begin
                    err_next = mhpq_pkg::ERR_FULL;
                end
                else
                begin
                    ctrl.push  = accept;
                    count_next = count_reg + OCC_W'(1);
                end
            end
            mhpq_pkg::CMD_POP:
            begin
                if (count_reg == '0)
                begin
                    err_next = mhpq_pkg::ERR_EMPTY;
                end
                else
                begin
                    ctrl.pop   = accept;
                    count_next = count_reg - OCC_W'(1);
                end
            end
            mhpq_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            localparam logic [OCC_W-1:0] IDX = OCC_W'(i);
            logic signed [DATA_WIDTH-1:0] prev_data;
            logic                         prev_gt;
            logic signed [DATA_WIDTH-1:0] next_data;

            if (i == 0)
            begin : g_first
                assign prev_data = '0;
                assign prev_gt   = 1'b0;
            end
            else
            begin : g_inner
                assign prev_data = cell_data[i-1];
                assign prev_gt   = cell_gt[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign next_data = cell_data[i];
            end
            else
            begin : g_body
                assign next_data = cell_data[i+1];
            end

            mhpq_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .valid      (count_reg > IDX),
                .push_value (push_value),
                .prev_data  (prev_data),
                .prev_gt    (prev_gt),
                .next_data  (next_data),
                .data       (cell_data[i]),
                .data_next  (cell_data_next[i]),
                .gt         (cell_gt[i])
            );
        end
    endgenerate

    assign top_ext_next = 64'(cell_data_next[0]);
    assign top_ext_now  = 64'(cell_data[0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_reg   <= (count_next == '0) ? '0 : top_ext_next[mhpq_pkg::TOP_W-1:0];
            occ_reg   <= count_next;
            empty_reg <= (count_next == '0);
            err_reg   <= err_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({err_reg, empty_reg, occ_reg, top_reg});

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= OCC_W'(CAPACITY))
        else $error("element count above capacity");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (empty_reg == (occ_reg == '0)))
        else $error("empty flag disagrees with occupancy");

    a_full_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (err_reg == mhpq_pkg::ERR_FULL) |-> (occ_reg == OCC_W'(CAPACITY)))
        else $error("push dropped while queue not full");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push |=> (count_reg == $past(count_reg) + OCC_W'(1)))
        else $error("push did not grow the queue by one");

    a_top_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !empty_reg |-> (top_reg == top_ext_now[mhpq_pkg::TOP_W-1:0]))
        else $error("reported maximum differs from head cell");

endmodule
